[rtl/srsss_pkg.sv]
// Shared types, codes and constants for the scaled reading seven-segment scan block.
package srsss_pkg;

   localparam int SAMPLE_W = 8;
   localparam int VALUE_W  = 9;
   localparam int PROD_W   = 31;

   // Reading = floor(sample * 1.9607), done as (sample * SCALE_MULT) >> SCALE_SHIFT.
   localparam int SCALE_SHIFT = 22;
   localparam logic [22:0] SCALE_MULT = 23'd8223772;

   localparam logic OP_CONVERT = 1'b0;
   localparam logic OP_TICK    = 1'b1;

   localparam logic CH_BAR     = 1'b0;
   localparam logic CH_READING = 1'b1;

   localparam logic [2:0] ENABLE_NONE     = 3'b000;
   localparam logic [2:0] ENABLE_UNITS    = 3'b100;
   localparam logic [2:0] ENABLE_TENS     = 3'b010;
   localparam logic [2:0] ENABLE_HUNDREDS = 3'b001;

   localparam logic [7:0] SEG_DP = 8'h01;

   typedef enum logic [2:0] {
      PH_BLANK_LOW  = 3'd0,
      PH_UNITS      = 3'd1,
      PH_TENS       = 3'd2,
      PH_HUNDREDS   = 3'd3,
      PH_BLANK_HIGH = 3'd4
   } phase_type;

   typedef struct packed {
      logic [2:0] hundreds;
      logic [3:0] tens;
      logic [3:0] units;
   } digits_type;

   function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
      logic [7:0] pattern;
      case (digit)
         4'd0:    pattern = 8'hFC;
         4'd1:    pattern = 8'h60;
         4'd2:    pattern = 8'hDA;
         4'd3:    pattern = 8'hF2;
         4'd4:    pattern = 8'h66;
         4'd5:    pattern = 8'hB6;
         4'd6:    pattern = 8'hBE;
         4'd7:    pattern = 8'hE0;
         4'd8:    pattern = 8'hFE;
         4'd9:    pattern = 8'hF6;
         default: pattern = 8'h00;
      endcase
      return pattern;
   endfunction

endpackage

[rtl/srsss_digit_split.sv]
// Splits a reading of 0..499 into hundreds, tens and units digits.
module srsss_digit_split
   import srsss_pkg::*;
(
   input  logic [VALUE_W-1:0] value,
   output digits_type         digits
);

   logic [2:0]         hundreds;
   logic [VALUE_W-1:0] rest;
   logic [6:0]         rest_low;
   logic [3:0]         tens;
   logic [6:0]         tens_weight;

   always_comb begin
      if (value >= 9'd400) begin
         hundreds = 3'd4;
         rest     = value - 9'd400;
      end else if (value >= 9'd300) begin
         hundreds = 3'd3;
         rest     = value - 9'd300;
      end else if (value >= 9'd200) begin
         hundreds = 3'd2;
         rest     = value - 9'd200;
      end else if (value >= 9'd100) begin
         hundreds = 3'd1;
         rest     = value - 9'd100;
      end else begin
         hundreds = 3'd0;
         rest     = value;
      end
   end

   assign rest_low = rest[6:0];

   always_comb begin
      tens = 4'd0;
      for (int k = 1; k < 10; k++) begin
         if (rest_low >= 7'(10 * k)) begin
            tens = 4'(k);
         end
      end
   end

   assign tens_weight = 7'({tens, 3'b000}) + 7'({tens, 1'b0});

   assign digits.hundreds = hundreds;
   assign digits.tens     = tens;
   assign digits.units    = 4'(rest_low - tens_weight);

endmodule

[rtl/scaled_reading_seven_segment_scan.sv]
// Top level of the scaled reading seven-segment scan block.
//
//   Channel   Direction  Payload
//   req_      in         tuser[0] opcode, tuser[1] channel, tdata[7:0] sample
//   rsp_      out        tdata[7:0] bar_level, [15:8] segments, [18:16] digit_enable
//
// Each transfer passes an input register, where the reading is scaled, and then the
// state registers, which also form the result register.
// One transfer is taken every cycle while the result is not stalled; there are two register stages.
// Synchronous reset clears the valid flags and the state registers; the first result then builds on zeros.
// A stalled result holds the state, and the input register still takes one transfer.
module scaled_reading_seven_segment_scan
   import srsss_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] sample
   input  logic [1:0]  req_tuser,   // [0] opcode, [1] channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata    // [7:0] bar_level, [15:8] segments,
                                    // [18:16] digit_enable, [23:19] zero
);

   logic               s1_valid_ff, s1_valid_in;
   logic               s1_opcode_ff;
   logic               s1_channel_ff;
   logic [7:0]         s1_sample_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic               rsp_valid_ff, rsp_valid_in;

   logic [7:0]         bar_ff, bar_in;
   digits_type         digits_ff, digits_in;
   phase_type          phase_ff, phase_in;
   logic [7:0]         segment_ff, segment_in;
   logic [2:0]         enable_ff, enable_in;

   logic [PROD_W-1:0]  product;
   logic [VALUE_W-1:0] value;
   digits_type         split_digits;
   logic               req_take;
   logic               s1_advance;
   logic               is_tick;
   logic [7:0]         tick_segment;
   logic [2:0]         tick_enable;

   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_take   = req_tvalid && req_tready;

   assign product = PROD_W'(req_tdata) * PROD_W'(SCALE_MULT);
   assign value   = product[SCALE_SHIFT +: VALUE_W];

   always_comb begin
      if (req_take) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_opcode_ff  <= req_tuser[0];
         s1_channel_ff <= req_tuser[1];
         s1_sample_ff  <= req_tdata;
         s1_value_ff   <= value;
      end
   end

   srsss_digit_split u_digit_split (
      .value  (s1_value_ff),
      .digits (split_digits)
   );

   assign is_tick = s1_opcode_ff == OP_TICK;

   always_comb begin
      case (phase_ff)
         PH_UNITS:    phase_in = PH_TENS;
         PH_TENS:     phase_in = PH_HUNDREDS;
         PH_HUNDREDS: phase_in = PH_BLANK_HIGH;
         default:     phase_in = PH_UNITS;
      endcase
      if (!(s1_advance && is_tick)) begin
         phase_in = phase_ff;
      end
   end

   always_comb begin
      case (phase_ff)
         PH_UNITS: begin
            tick_enable  = ENABLE_UNITS;
            tick_segment = seg_pattern(digits_ff.units);
         end
         PH_TENS: begin
            tick_enable  = ENABLE_TENS;
            tick_segment = seg_pattern(digits_ff.tens);
         end
         PH_HUNDREDS: begin
            tick_enable  = ENABLE_HUNDREDS;
            tick_segment = seg_pattern({1'b0, digits_ff.hundreds}) | SEG_DP;
         end
         default: begin
            tick_enable  = ENABLE_NONE;
            tick_segment = segment_ff;
         end
      endcase
   end

   always_comb begin
      bar_in       = bar_ff;
      digits_in    = digits_ff;
      segment_in   = segment_ff;
      enable_in    = enable_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_advance) begin
         rsp_valid_in = 1'b1;
         if (is_tick) begin
            segment_in = tick_segment;
            enable_in  = tick_enable;
         end else if (s1_channel_ff == CH_BAR) begin
            bar_in = s1_sample_ff;
         end else begin
            digits_in = split_digits;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         bar_ff       <= '0;
         digits_ff    <= '0;
         phase_ff     <= PH_BLANK_LOW;
         segment_ff   <= '0;
         enable_ff    <= ENABLE_NONE;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         bar_ff       <= bar_in;
         digits_ff    <= digits_in;
         phase_ff     <= phase_in;
         segment_ff   <= segment_in;
         enable_ff    <= enable_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b00000, enable_ff, segment_ff, bar_ff};

`ifndef SYNTHESIS
   a_one_digit_lit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(enable_ff))
      else $error("More than one digit enabled.");

   a_hundreds_has_point: assert property (@(posedge clock) disable iff (reset)
      (enable_ff == ENABLE_HUNDREDS) |-> segment_ff[0])
      else $error("Hundreds digit lit without decimal point.");

   a_units_then_tens: assert property (@(posedge clock) disable iff (reset)
      (enable_ff == ENABLE_UNITS) |-> (phase_ff == PH_TENS))
      else $error("Scan phase out of step with the units digit.");

   a_tens_then_hundreds: assert property (@(posedge clock) disable iff (reset)
      (enable_ff == ENABLE_TENS) |-> (phase_ff == PH_HUNDREDS))
      else $error("Scan phase out of step with the tens digit.");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && s1_valid_ff) |-> s1_advance)
      else $error("Input register overwritten before it moved on.");

   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_tvalid)
      else $error("Processed transfer produced no result.");
`endif

endmodule
